/* rtl/core/stride_prefetch_table_defines.svh */
// Assertion macros shared by the stride prefetch table RTL.
`ifndef STRIDE_PREFETCH_TABLE_DEFINES_SVH
`define STRIDE_PREFETCH_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stride_prefetch_table: same-cycle check failed");

// Next-cycle implication, checked on every clock outside reset.
`define SPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stride_prefetch_table: next-cycle check failed");

`endif

/* rtl/core/spt_pkg.sv */
// Types and constants of the stride prefetch table.
`default_nettype none

package spt_pkg;

    localparam int ADDR_W      = 32;
    localparam int LOOKAHEAD_W = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    typedef logic [1:0] t_status;

    // Entry status codes; the fourth code is never stored.
    localparam t_status ST_INVALID  = 2'd0;
    localparam t_status ST_TRAINING = 2'd1;
    localparam t_status ST_ACTIVE   = 2'd2;

    // Command codes carried on tuser.
    localparam logic CMD_INSN   = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    // Register word index taken from paddr[2].
    localparam logic REG_LOOKAHEAD = 1'b0;
    localparam logic [LOOKAHEAD_W-1:0] LOOKAHEAD_RST = 8'd4;

    // One table entry as stored in the memory.
    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   stride;
        logic [ADDR_W-1:0]   last;
        logic [ADDR_W-1:0]   tag;
    } t_entry;

    // Access strobes from the sequencer to the table.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

endpackage

`default_nettype wire

/* rtl/core/spt_table.sv */
// Entry memory of the stride prefetch table with per-entry written flags.
`default_nettype none

module spt_table import spt_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_tbl_ctl         i_ctl,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  wire t_entry           i_wr_entry,
    output t_entry                o_rd_entry
);

    t_entry             r_mem [ENTRIES];
    t_entry             r_rdata;
    logic [ENTRIES-1:0] r_written;
    logic               r_rd_written;

    // Synchronous memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_rd_idx];
        end
    end

    // Written flags stand in for clearing the memory at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_written[i_wr_idx] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_written <= r_written[i_rd_idx];
            end
        end
    end

    // An entry never written reads as the reset value: all zero, invalid.
    assign o_rd_entry = r_rd_written ? r_rdata : '0;

endmodule

`default_nettype wire

/* rtl/core/stride_prefetch_table.sv */
// Top level of the PC-indexed stride prefetch table.
//
//  Channel  | Direction | Handshake                | Word contents
//  s_axis   | in        | tvalid/tready            | tuser: command; tdata: pc, address, misses
//  m_axis   | out       | tvalid/tready            | tdata: prefetch valid, address, pc active
//  apb      | in        | psel/penable/pwrite      | register 0 at byte 0: lookahead distance
//
// After acceptance, an instruction event scans every entry and then delivers its result word.
// A data access with an L1 miss scans, then writes back, then delivers; an L1 hit delivers
// without a scan. The next word is taken only once the sequencer is back in idle, so items
// do not overlap. The scan reads every entry through the one read port of the table memory.
// Reset is synchronous and clears control state and written flags.
// A result word still waiting on m_axis holds the sequencer only once the next result is ready.
`default_nettype none

`include "stride_prefetch_table_defines.svh"

module stride_prefetch_table import spt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input words
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [31:0] pc, [63:32] data_address, [64] l1_miss, [65] l2_miss
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] command
    input  wire logic                   i_s_axis_tuser,
    // Result words
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [0] prefetch_valid, [32:1] prefetch_address, [33] pc_active
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // Configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Control state
    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_rd_cnt, n_rd_cnt;
    logic                   r_chk_vld, n_chk_vld;
    logic                   r_hit, n_hit;
    logic                   r_any_active, n_any_active;
    logic                   r_out_valid, n_out_valid;
    logic [LOOKAHEAD_W-1:0] r_lookahead;

    // Item and scan payload
    logic                   r_cmd, n_cmd;
    logic                   r_l1, n_l1;
    logic                   r_l2, n_l2;
    logic [ADDR_W-1:0]      r_key, n_key;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [IDX_W-1:0]       r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]       r_hit_idx, n_hit_idx;
    logic [ADDR_W-1:0]      r_hit_last, n_hit_last;
    logic [ADDR_W-1:0]      r_hit_stride, n_hit_stride;
    t_status                r_hit_status, n_hit_status;
    logic [IDX_W-1:0]       r_vic_idx, n_vic_idx;
    t_status                r_vic_status, n_vic_status;
    logic [ADDR_W-1:0]      r_pf_addr, n_pf_addr;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Table interface
    t_tbl_ctl               tbl_ctl;
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       wr_idx;
    t_entry                 wr_entry;
    t_entry                 rd_entry;

    logic                   in_acc;
    logic                   out_load;
    logic                   cfg_wr;
    logic                   tag_match;
    logic [ADDR_W-1:0]      delta;
    logic                   res_pf_valid;
    logic                   res_pc_active;
    logic                   scan_last;

    spt_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_rd_idx   (rd_idx),
        .i_wr_idx   (wr_idx),
        .i_wr_entry (wr_entry),
        .o_rd_entry (rd_entry)
    );

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Configuration port: one register, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LOOKAHEAD);
    assign prdata = (paddr[2] == REG_LOOKAHEAD) ? {24'd0, r_lookahead} : 32'd0;

    assign tag_match = (rd_entry.tag == r_key);
    assign delta     = r_addr - r_hit_last;
    assign rd_idx    = r_rd_cnt[IDX_W-1:0];
    assign wr_idx    = r_hit ? r_hit_idx : r_vic_idx;

    // The last entry of a scan is being examined.
    assign scan_last = (r_state == S_SCAN) && r_chk_vld
                       && (r_chk_idx == IDX_W'(TABLE_ENTRIES - 1));

    // Result fields, formed from the finished scan.
    assign res_pf_valid  = (r_cmd == CMD_INSN) && r_hit;
    assign res_pc_active = (r_cmd == CMD_ACCESS) && r_l1 && !r_l2 && r_any_active;

    // Sequencer: accept, scan every entry (not for an L1 hit), write back (data misses only), deliver.
    always_comb begin
        n_state      = r_state;
        n_rd_cnt     = r_rd_cnt;
        n_chk_vld    = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_hit        = r_hit;
        n_any_active = r_any_active;
        n_cmd        = r_cmd;
        n_l1         = r_l1;
        n_l2         = r_l2;
        n_key        = r_key;
        n_addr       = r_addr;
        n_hit_idx    = r_hit_idx;
        n_hit_last   = r_hit_last;
        n_hit_stride = r_hit_stride;
        n_hit_status = r_hit_status;
        n_vic_idx    = r_vic_idx;
        n_vic_status = r_vic_status;
        n_pf_addr    = r_pf_addr;
        tbl_ctl      = '0;
        wr_entry     = '0;
        out_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd        = i_s_axis_tuser;
                    n_addr       = i_s_axis_tdata[63:32];
                    n_l1         = (i_s_axis_tuser == CMD_ACCESS) && i_s_axis_tdata[64];
                    n_l2         = i_s_axis_tdata[65];
                    n_key        = (i_s_axis_tuser == CMD_INSN)
                                 ? i_s_axis_tdata[31:0] + {24'd0, r_lookahead}
                                 : i_s_axis_tdata[31:0];
                    n_hit        = 1'b0;
                    n_any_active = 1'b0;
                    n_rd_cnt     = '0;
                    n_vic_idx    = '0;
                    n_vic_status = ST_INVALID;
                    n_state      = ((i_s_axis_tuser == CMD_ACCESS) && !i_s_axis_tdata[64])
                                 ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue one read per cycle until every entry is requested.
                if (r_rd_cnt != CNT_W'(TABLE_ENTRIES)) begin
                    tbl_ctl.rd_en = 1'b1;
                    n_rd_cnt      = r_rd_cnt + CNT_W'(1);
                end
                n_chk_vld = tbl_ctl.rd_en;
                n_chk_idx = rd_idx;
                // Examine the entry read in the previous cycle.
                if (r_chk_vld) begin
                    if (r_cmd == CMD_INSN) begin
                        if (tag_match && (rd_entry.status == ST_ACTIVE) && !r_hit) begin
                            n_hit     = 1'b1;
                            n_pf_addr = rd_entry.last + rd_entry.stride;
                        end
                    end else begin
                        if (tag_match && (rd_entry.status != ST_INVALID) && !r_hit) begin
                            n_hit        = 1'b1;
                            n_hit_idx    = r_chk_idx;
                            n_hit_last   = rd_entry.last;
                            n_hit_stride = rd_entry.stride;
                            n_hit_status = rd_entry.status;
                        end
                        if (tag_match && (rd_entry.status == ST_ACTIVE)) begin
                            n_any_active = 1'b1;
                        end
                        // Victim: invalid beats training, anything not active beats active.
                        if (r_chk_idx == '0) begin
                            n_vic_idx    = '0;
                            n_vic_status = rd_entry.status;
                        end else if (((r_vic_status == ST_TRAINING)
                                      && (rd_entry.status == ST_INVALID))
                                  || ((r_vic_status == ST_ACTIVE)
                                      && (rd_entry.status != ST_ACTIVE))) begin
                            n_vic_idx    = r_chk_idx;
                            n_vic_status = rd_entry.status;
                        end
                    end
                    if (r_chk_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        n_state = (r_cmd == CMD_INSN) ? S_DONE : S_WB;
                    end
                end
            end
            S_WB: begin
                wr_entry.tag = r_key;
                if (r_l2 && !r_hit) begin
                    // A fresh entry trains on its own access and turns active at once.
                    tbl_ctl.wr_en   = 1'b1;
                    wr_entry.last   = r_addr;
                    wr_entry.stride = '0;
                    wr_entry.status = ST_ACTIVE;
                end else if (r_hit) begin
                    tbl_ctl.wr_en = 1'b1;
                    if (r_hit_stride == delta) begin
                        wr_entry.last   = r_addr;
                        wr_entry.stride = r_hit_stride;
                        wr_entry.status = ST_ACTIVE;
                    end else if (r_hit_status == ST_TRAINING) begin
                        wr_entry.last   = r_addr;
                        wr_entry.stride = delta;
                        wr_entry.status = ST_TRAINING;
                    end else begin
                        wr_entry.last   = r_hit_last;
                        wr_entry.stride = r_hit_stride;
                        wr_entry.status = ST_INVALID;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register empties when taken and fills from the sequencer.
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_cnt     <= '0;
            r_chk_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_any_active <= 1'b0;
            r_out_valid  <= 1'b0;
            r_lookahead  <= LOOKAHEAD_RST;
        end else begin
            r_state      <= n_state;
            r_rd_cnt     <= n_rd_cnt;
            r_chk_vld    <= n_chk_vld;
            r_hit        <= n_hit;
            r_any_active <= n_any_active;
            r_out_valid  <= n_out_valid;
            if (cfg_wr) begin
                r_lookahead <= pwdata[LOOKAHEAD_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_l1         <= n_l1;
        r_l2         <= n_l2;
        r_key        <= n_key;
        r_addr       <= n_addr;
        r_chk_idx    <= n_chk_idx;
        r_hit_idx    <= n_hit_idx;
        r_hit_last   <= n_hit_last;
        r_hit_stride <= n_hit_stride;
        r_hit_status <= n_hit_status;
        r_vic_idx    <= n_vic_idx;
        r_vic_status <= n_vic_status;
        r_pf_addr    <= n_pf_addr;
        if (out_load) begin
            r_out_data <= {6'd0, res_pc_active,
                           res_pf_valid ? r_pf_addr : {ADDR_W{1'b0}}, res_pf_valid};
        end
    end

    // Checks on the sequencer.
    `SPT_ASSERT_IMP(a_wr_only_in_wb, tbl_ctl.wr_en, r_state == S_WB)
    `SPT_ASSERT_IMP(a_wr_only_on_miss, tbl_ctl.wr_en, (r_cmd == CMD_ACCESS) && r_l1)
    `SPT_ASSERT_IMP(a_no_result_clobber, out_load, !r_out_valid || i_m_axis_tready)
    `SPT_ASSERT_NEXT(a_scan_ends, scan_last, r_state != S_SCAN)

endmodule

`default_nettype wire
